@@ rtl/core/asl_pkg.sv @@
// Shared types, request codes and constants of the alarm slot table.
package asl_pkg;

    localparam int NUM_SLOTS_DEF = 8;
    localparam int MAX_FIRE      = 8;
    localparam int FIRE_CNT_W    = 4;
    localparam int SUM_W         = 8;
    localparam int SEC_PER_MIN   = 60;
    localparam int HOURS_PER_DAY = 24;

    typedef enum logic [1:0] {
        REQ_ARM_ABS = 2'd0,
        REQ_ARM_REL = 2'd1,
        REQ_FREE    = 2'd2,
        REQ_TICK    = 2'd3
    } t_req;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_hms;

    // One digit step of the mixed-radix adder.
    typedef struct packed {
        logic [5:0] op_a;
        logic [5:0] op_b;
        logic [1:0] carry_in;
        logic       sel_hour;
    } t_add_in;

    typedef struct packed {
        logic [5:0] digit;
        logic [1:0] carry_out;
    } t_add_out;

    typedef struct packed {
        logic en;
        logic arm;
    } t_wr_ctl;

endpackage

@@ rtl/core/asl_time_unit.sv @@
// Shared time arithmetic: one digit add with carry and modulo reduction, and a time compare.
module asl_time_unit (
    input  asl_pkg::t_add_in  i_add,
    output asl_pkg::t_add_out o_add,
    input  asl_pkg::t_hms     i_alarm,
    input  asl_pkg::t_hms     i_now,
    output logic              o_due
);

    logic [asl_pkg::SUM_W-1:0] w_sum;
    logic [asl_pkg::SUM_W-1:0] w_mod;
    logic [asl_pkg::SUM_W-1:0] w_mod2;

    // The sum stays below three times the modulus, so two compares suffice.
    always_comb begin
        w_sum  = asl_pkg::SUM_W'(i_add.op_a) + asl_pkg::SUM_W'(i_add.op_b)
               + asl_pkg::SUM_W'(i_add.carry_in);
        w_mod  = i_add.sel_hour ? asl_pkg::SUM_W'(asl_pkg::HOURS_PER_DAY)
                                : asl_pkg::SUM_W'(asl_pkg::SEC_PER_MIN);
        w_mod2 = w_mod << 1;
        if (w_sum >= w_mod2) begin
            o_add.digit     = 6'(w_sum - w_mod2);
            o_add.carry_out = 2'd2;
        end else if (w_sum >= w_mod) begin
            o_add.digit     = 6'(w_sum - w_mod);
            o_add.carry_out = 2'd1;
        end else begin
            o_add.digit     = 6'(w_sum);
            o_add.carry_out = 2'd0;
        end
    end

    always_comb begin
        if (i_alarm.hour != i_now.hour) begin
            o_due = i_alarm.hour < i_now.hour;
        end else if (i_alarm.minute != i_now.minute) begin
            o_due = i_alarm.minute < i_now.minute;
        end else begin
            o_due = i_alarm.second <= i_now.second;
        end
    end

endmodule

@@ rtl/core/asl_slot_regs.sv @@
// Slot storage: alarm time per slot and the armed flags, one write and one read port.
module asl_slot_regs #(
    parameter int NUM_SLOTS = asl_pkg::NUM_SLOTS_DEF,
    parameter int IW        = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  asl_pkg::t_wr_ctl  i_wr,
    input  logic [IW-1:0]     i_wr_addr,
    input  asl_pkg::t_hms     i_wr_hms,
    input  logic [IW-1:0]     i_rd_addr,
    output asl_pkg::t_hms     o_rd_hms,
    output logic [NUM_SLOTS-1:0] o_armed
);

    asl_pkg::t_hms        r_alarm_time [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_armed;

    // Alarm times are only read for armed slots, and arming always writes them.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_alarm_time[i_wr_addr] <= i_wr_hms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= '0;
        end else if (i_wr.en) begin
            r_armed[i_wr_addr] <= i_wr.arm;
        end
    end

    assign o_rd_hms = r_alarm_time[i_rd_addr];
    assign o_armed  = r_armed;

endmodule

@@ rtl/core/alarm_slot_table.sv @@
// Top level of the alarm slot table: request sequencer, output register and slot walk.
//
//  channel  | dir | tdata (low bit up)                              | tuser      | tlast
//  s_axis   | in  | slot, time h/m/s, now h/m/s (37 of 40 bits)     | req_type   | -
//  m_axis   | out | fired_slot, armed_mask (11 of 16 bits)          | fire_valid | last_result
//
// Arm absolute, free and out-of-range requests go from the accept straight to the emit state;
// arm after now first takes three add steps through the shared digit adder. A tick walks
// the slots in order, reading each one and comparing it through the shared compare, and
// then flushes the final transaction.
// Reset clears the armed flags at once; no clearing pass is needed.
// A full output register stalls the walk at the next slot that fires while a fire is held.
module alarm_slot_table #(
    parameter int NUM_SLOTS = asl_pkg::NUM_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // slot[2:0], time_hour[7:3], time_minute[13:8], time_second[19:14],
    // now_hour[24:20], now_minute[30:25], now_second[36:31], zero pad[39:37]
    input  logic [39:0] s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // fired_slot[2:0], armed_mask[10:3], zero pad[15:11]
    output logic [15:0] m_axis_tdata,
    // fire_valid[0]
    output logic [0:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int MW = (NUM_SLOTS < 8) ? NUM_SLOTS : 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_EMIT,
        S_WALK,
        S_FLUSH
    } t_state;

    typedef enum logic [1:0] {
        STEP_SEC,
        STEP_MIN,
        STEP_HOUR
    } t_step;

    t_state r_state, n_state;
    t_step  r_step, n_step;
    logic [2:0]    r_slot, n_slot;
    asl_pkg::t_hms r_time, n_time;
    asl_pkg::t_hms r_now, n_now;
    logic [1:0]    r_carry, n_carry;
    logic [5:0]    r_sec, n_sec;
    logic [5:0]    r_min, n_min;
    logic [IW-1:0] r_idx, n_idx;
    logic [asl_pkg::FIRE_CNT_W-1:0] r_fire_cnt, n_fire_cnt;
    logic          r_pend_valid, n_pend_valid;
    logic [IW-1:0] r_pend_idx, n_pend_idx;
    logic [7:0]    r_pend_mask, n_pend_mask;
    logic          r_out_valid, n_out_valid;
    logic          r_out_fire, n_out_fire;
    logic [2:0]    r_out_slot, n_out_slot;
    logic          r_out_last, n_out_last;
    logic [7:0]    r_out_mask, n_out_mask;

    logic [2:0]    w_in_slot;
    asl_pkg::t_hms w_in_time;
    asl_pkg::t_hms w_in_now;
    logic          w_slot_ok;
    logic          w_accept;
    logic          w_out_free;
    logic          w_last_idx;

    asl_pkg::t_wr_ctl w_wr;
    logic [IW-1:0]    w_wr_addr;
    asl_pkg::t_hms    w_wr_hms;
    asl_pkg::t_hms    w_rd_hms;
    logic [NUM_SLOTS-1:0] w_armed;
    logic [NUM_SLOTS-1:0] w_armed_clr;
    logic [7:0]       w_mask;
    logic [7:0]       w_mask_clr;

    asl_pkg::t_add_in  w_add_in;
    asl_pkg::t_add_out w_add_out;
    logic              w_due;

    assign w_in_slot        = s_axis_tdata[2:0];
    assign w_in_time.hour   = s_axis_tdata[7:3];
    assign w_in_time.minute = s_axis_tdata[13:8];
    assign w_in_time.second = s_axis_tdata[19:14];
    assign w_in_now.hour    = s_axis_tdata[24:20];
    assign w_in_now.minute  = s_axis_tdata[30:25];
    assign w_in_now.second  = s_axis_tdata[36:31];

    assign w_slot_ok   = int'(w_in_slot) < NUM_SLOTS;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_last_idx  = (r_idx == IW'(NUM_SLOTS - 1));

    // The mask shown with a fire already has that slot disarmed.
    assign w_armed_clr = w_armed & ~(NUM_SLOTS'(1) << r_idx);
    assign w_mask      = 8'(w_armed[MW-1:0]);
    assign w_mask_clr  = 8'(w_armed_clr[MW-1:0]);

    asl_slot_regs #(
        .NUM_SLOTS (NUM_SLOTS),
        .IW        (IW)
    ) u_slots (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_wr_addr (w_wr_addr),
        .i_wr_hms  (w_wr_hms),
        .i_rd_addr (r_idx),
        .o_rd_hms  (w_rd_hms),
        .o_armed   (w_armed)
    );

    asl_time_unit u_time (
        .i_add   (w_add_in),
        .o_add   (w_add_out),
        .i_alarm (w_rd_hms),
        .i_now   (r_now),
        .o_due   (w_due)
    );

    always_comb begin
        w_add_in.sel_hour = 1'b0;
        w_add_in.carry_in = r_carry;
        case (r_step)
            STEP_SEC: begin
                w_add_in.op_a = r_now.second;
                w_add_in.op_b = r_time.second;
            end
            STEP_MIN: begin
                w_add_in.op_a = r_now.minute;
                w_add_in.op_b = r_time.minute;
            end
            default: begin
                w_add_in.op_a     = 6'(r_now.hour);
                w_add_in.op_b     = 6'(r_time.hour);
                w_add_in.sel_hour = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_slot       = r_slot;
        n_time       = r_time;
        n_now        = r_now;
        n_carry      = r_carry;
        n_sec        = r_sec;
        n_min        = r_min;
        n_idx        = r_idx;
        n_fire_cnt   = r_fire_cnt;
        n_pend_valid = r_pend_valid;
        n_pend_idx   = r_pend_idx;
        n_pend_mask  = r_pend_mask;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_fire   = r_out_fire;
        n_out_slot   = r_out_slot;
        n_out_last   = r_out_last;
        n_out_mask   = r_out_mask;
        w_wr.en      = 1'b0;
        w_wr.arm     = 1'b0;
        w_wr_addr    = IW'(r_slot);
        w_wr_hms     = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_slot  = w_in_slot;
                    n_time  = w_in_time;
                    n_now   = w_in_now;
                    n_carry = 2'd0;
                    n_step  = STEP_SEC;
                    n_state = S_EMIT;
                    case (asl_pkg::t_req'(s_axis_tuser))
                        asl_pkg::REQ_TICK: begin
                            n_state      = S_WALK;
                            n_idx        = '0;
                            n_fire_cnt   = '0;
                            n_pend_valid = 1'b0;
                        end
                        asl_pkg::REQ_ARM_ABS: begin
                            w_wr.en   = w_slot_ok;
                            w_wr.arm  = 1'b1;
                            w_wr_addr = IW'(w_in_slot);
                            w_wr_hms  = w_in_time;
                        end
                        asl_pkg::REQ_FREE: begin
                            w_wr.en   = w_slot_ok;
                            w_wr_addr = IW'(w_in_slot);
                        end
                        default: begin
                            if (w_slot_ok) begin
                                n_state = S_ADD;
                            end
                        end
                    endcase
                end
            end
            S_ADD: begin
                n_carry = w_add_out.carry_out;
                case (r_step)
                    STEP_SEC: begin
                        n_sec  = w_add_out.digit;
                        n_step = STEP_MIN;
                    end
                    STEP_MIN: begin
                        n_min  = w_add_out.digit;
                        n_step = STEP_HOUR;
                    end
                    default: begin
                        w_wr.en         = 1'b1;
                        w_wr.arm        = 1'b1;
                        w_wr_hms.hour   = w_add_out.digit[4:0];
                        w_wr_hms.minute = r_min;
                        w_wr_hms.second = r_sec;
                        n_state         = S_EMIT;
                    end
                endcase
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_fire  = 1'b0;
                    n_out_slot  = 3'd0;
                    n_out_last  = 1'b1;
                    n_out_mask  = w_mask;
                    n_state     = S_IDLE;
                end
            end
            S_WALK: begin
                if (w_armed[r_idx] && w_due) begin
                    // A fire is held back until the next one shows it is not the last.
                    if (!r_pend_valid || w_out_free) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_fire  = 1'b1;
                            n_out_slot  = 3'(r_pend_idx);
                            n_out_last  = 1'b0;
                            n_out_mask  = r_pend_mask;
                        end
                        w_wr.en      = 1'b1;
                        w_wr_addr    = r_idx;
                        n_pend_valid = 1'b1;
                        n_pend_idx   = r_idx;
                        n_pend_mask  = w_mask_clr;
                        n_fire_cnt   = r_fire_cnt + 1'b1;
                        if (w_last_idx ||
                            n_fire_cnt == asl_pkg::FIRE_CNT_W'(asl_pkg::MAX_FIRE)) begin
                            n_state = S_FLUSH;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                end else if (w_last_idx) begin
                    n_state = S_FLUSH;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_fire   = r_pend_valid;
                    n_out_slot   = r_pend_valid ? 3'(r_pend_idx) : 3'd0;
                    n_out_last   = 1'b1;
                    n_out_mask   = r_pend_valid ? r_pend_mask : w_mask;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step       <= STEP_SEC;
            r_idx        <= '0;
            r_fire_cnt   <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_step       <= n_step;
            r_idx        <= n_idx;
            r_fire_cnt   <= n_fire_cnt;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
        r_slot      <= n_slot;
        r_time      <= n_time;
        r_now       <= n_now;
        r_carry     <= n_carry;
        r_sec       <= n_sec;
        r_min       <= n_min;
        r_pend_idx  <= n_pend_idx;
        r_pend_mask <= n_pend_mask;
        r_out_fire  <= n_out_fire;
        r_out_slot  <= n_out_slot;
        r_out_last  <= n_out_last;
        r_out_mask  <= n_out_mask;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_mask, r_out_slot};
    assign m_axis_tuser  = r_out_fire;
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTH
    a_pend_disarmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> !w_armed[r_pend_idx])
        else $error("held fire refers to a slot that is still armed");

    a_walk_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_fire_cnt < asl_pkg::FIRE_CNT_W'(asl_pkg::MAX_FIRE)))
        else $error("walk continues after the fire limit");

    a_add_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD && r_step != STEP_HOUR) |-> !w_wr.en)
        else $error("slot written before the hour step");

    a_tick_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tuser == asl_pkg::REQ_TICK) |=>
        (r_state == S_WALK && r_idx == '0 && !r_pend_valid))
        else $error("tick did not start the walk at slot zero");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking stream testbench of the alarm slot table, with its own slot-table predictor.
module tb_top;

    typedef struct packed {
        asl_pkg::t_req req;
        logic [2:0] slot;
        logic [4:0] t_h;
        logic [5:0] t_m;
        logic [5:0] t_s;
        logic [4:0] n_h;
        logic [5:0] n_m;
        logic [5:0] n_s;
    } t_alarm_req;

    typedef struct packed {
        logic       fire;
        logic [2:0] slot;
        logic       last;
        logic [7:0] mask;
    } t_alarm_result;

    typedef struct packed {
        t_alarm_req    rq;
        logic          typed;
        t_alarm_result want;
    } t_dir_row;

    localparam int DIR_ROWS     = 24;
    localparam int RAND_ITEMS   = 200;
    localparam int SECS_PER_DAY =
        asl_pkg::HOURS_PER_DAY * asl_pkg::SEC_PER_MIN * asl_pkg::SEC_PER_MIN;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = asl_pkg::REQ_TICK;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // Predictor copy of the slot table.
    logic [4:0]                        due_hour [asl_pkg::NUM_SLOTS_DEF];
    logic [5:0]                        due_min  [asl_pkg::NUM_SLOTS_DEF];
    logic [5:0]                        due_sec  [asl_pkg::NUM_SLOTS_DEF];
    logic [asl_pkg::NUM_SLOTS_DEF-1:0] armed_slots = '0;

    t_alarm_result step_reports[$];
    t_alarm_result awaited_reports[$];

    int mismatch_count = 0;
    int idle_pct       = 25;
    int rx_hold        = 0;
    int day_clock      = 0;

    // Rows marked typed carry an expectation that can be read off directly.
    t_dir_row dir_tab [DIR_ROWS] = '{
        '{'{asl_pkg::REQ_TICK,    0,  0,  0,  0,  0,  0,  0}, 1, '{0, 0, 1, 8'h00}},
        '{'{asl_pkg::REQ_ARM_ABS, 0,  0,  0,  0,  0,  0,  0}, 1, '{0, 0, 1, 8'h01}},
        '{'{asl_pkg::REQ_ARM_ABS, 7, 23, 59, 59,  0,  0,  0}, 1, '{0, 0, 1, 8'h81}},
        '{'{asl_pkg::REQ_TICK,    0, 31, 63, 63,  0,  0,  0}, 1, '{1, 0, 1, 8'h80}},
        // Offsets that carry through every digit, then all-ones fields.
        '{'{asl_pkg::REQ_ARM_REL, 3, 23, 59, 59, 23, 59, 59}, 1, '{0, 0, 1, 8'h88}},
        '{'{asl_pkg::REQ_ARM_REL, 1, 31, 63, 63, 31, 63, 63}, 1, '{0, 0, 1, 8'h8A}},
        '{'{asl_pkg::REQ_FREE,    7,  0,  0,  0,  0,  0,  0}, 1, '{0, 0, 1, 8'h0A}},
        '{'{asl_pkg::REQ_FREE,    5, 31, 63, 63, 31, 63, 63}, 1, '{0, 0, 1, 8'h0A}},
        '{'{asl_pkg::REQ_ARM_ABS, 2, 31, 63, 63,  0,  0,  0}, 1, '{0, 0, 1, 8'h0E}},
        '{'{asl_pkg::REQ_ARM_ABS, 3, 12, 30,  0,  0,  0,  0}, 1, '{0, 0, 1, 8'h0E}},
        '{'{asl_pkg::REQ_TICK,    0,  0,  0,  0, 12, 29, 59}, 1, '{0, 0, 1, 8'h0E}},
        '{'{asl_pkg::REQ_TICK,    0,  0,  0,  0, 12, 30,  0}, 1, '{1, 3, 1, 8'h06}},
        // Fill the table; the first tick needs a true time order, not per-field.
        '{'{asl_pkg::REQ_ARM_ABS, 0,  1,  0,  0,  0,  0,  0}, 0, '{0, 0, 0, 8'h00}},
        '{'{asl_pkg::REQ_ARM_ABS, 4,  0, 59, 59,  0,  0,  0}, 0, '{0, 0, 0, 8'h00}},
        '{'{asl_pkg::REQ_ARM_ABS, 5,  1,  0,  1,  0,  0,  0}, 0, '{0, 0, 0, 8'h00}},
        '{'{asl_pkg::REQ_ARM_ABS, 6,  0, 30, 59,  0,  0,  0}, 0, '{0, 0, 0, 8'h00}},
        '{'{asl_pkg::REQ_ARM_ABS, 7,  0,  0,  0,  0,  0,  0}, 0, '{0, 0, 0, 8'h00}},
        '{'{asl_pkg::REQ_ARM_REL, 3,  0,  0,  0, 31, 63, 63}, 0, '{0, 0, 0, 8'h00}},
        '{'{asl_pkg::REQ_TICK,    0,  0,  0,  0,  1,  0,  0}, 0, '{0, 0, 0, 8'h00}},
        '{'{asl_pkg::REQ_TICK,    0,  0,  0,  0, 31, 63, 63}, 0, '{0, 0, 0, 8'h00}},
        '{'{asl_pkg::REQ_TICK,    0,  0,  0,  0,  0,  0,  0}, 1, '{0, 0, 1, 8'h00}},
        // An alarm set for exactly now fires on the first tick at that time.
        '{'{asl_pkg::REQ_ARM_REL, 4,  0,  0,  0, 10, 20, 30}, 1, '{0, 0, 1, 8'h10}},
        '{'{asl_pkg::REQ_TICK,    0,  0,  0,  0, 10, 20, 29}, 1, '{0, 0, 1, 8'h10}},
        '{'{asl_pkg::REQ_TICK,    0,  0,  0,  0, 10, 20, 30}, 1, '{1, 4, 1, 8'h00}}
    };

    alarm_slot_table DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ERROR: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic asl_pkg::t_hms hms_of(input int secs);
        asl_pkg::t_hms t;
        t.hour   = 5'(secs / 3600);
        t.minute = 6'((secs / asl_pkg::SEC_PER_MIN) % asl_pkg::SEC_PER_MIN);
        t.second = 6'(secs % asl_pkg::SEC_PER_MIN);
        return t;
    endfunction

    // Applies one request to the predicted table and leaves its reports in step_reports.
    function automatic void alarm_table_step(input t_alarm_req rq);
        int            sec_sum;
        int            min_sum;
        int            hour_sum;
        t_alarm_result r;
        step_reports.delete();
        if (rq.req == asl_pkg::REQ_TICK) begin
            for (int s = 0; s < asl_pkg::NUM_SLOTS_DEF; s++) begin
                if (armed_slots[s] &&
                    {due_hour[s], due_min[s], due_sec[s]} <= {rq.n_h, rq.n_m, rq.n_s}) begin
                    armed_slots[s] = 1'b0;
                    due_hour[s]    = '0;
                    due_min[s]     = '0;
                    due_sec[s]     = '0;
                    r = '{1'b1, 3'(s), 1'b0, armed_slots};
                    step_reports.push_back(r);
                end
            end
            if (step_reports.size() == 0) begin
                step_reports.push_back('{1'b0, 3'd0, 1'b1, armed_slots});
            end else begin
                r = step_reports.pop_back();
                r.last = 1'b1;
                step_reports.push_back(r);
            end
            return;
        end
        case (rq.req)
            asl_pkg::REQ_ARM_ABS: begin
                due_hour[rq.slot] = rq.t_h;
                due_min[rq.slot]  = rq.t_m;
                due_sec[rq.slot]  = rq.t_s;
                armed_slots[rq.slot] = 1'b1;
            end
            asl_pkg::REQ_ARM_REL: begin
                sec_sum  = rq.n_s + rq.t_s;
                min_sum  = rq.n_m + rq.t_m + sec_sum / asl_pkg::SEC_PER_MIN;
                hour_sum = rq.n_h + rq.t_h + min_sum / asl_pkg::SEC_PER_MIN;
                due_sec[rq.slot]  = 6'(sec_sum % asl_pkg::SEC_PER_MIN);
                due_min[rq.slot]  = 6'(min_sum % asl_pkg::SEC_PER_MIN);
                due_hour[rq.slot] = 5'(hour_sum % asl_pkg::HOURS_PER_DAY);
                armed_slots[rq.slot] = 1'b1;
            end
            default: begin
                due_hour[rq.slot] = '0;
                due_min[rq.slot]  = '0;
                due_sec[rq.slot]  = '0;
                armed_slots[rq.slot] = 1'b0;
            end
        endcase
        step_reports.push_back('{1'b0, 3'd0, 1'b1, armed_slots});
    endfunction

    // Mostly requests that follow a running clock of the day, with some raw noise.
    function automatic t_alarm_req random_request();
        t_alarm_req    rq;
        asl_pkg::t_hms now_t;
        asl_pkg::t_hms due_t;
        int            pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            rq.req  = asl_pkg::t_req'($urandom_range(0, 3));
            rq.slot = 3'($urandom);
            rq.t_h  = 5'($urandom);
            rq.t_m  = 6'($urandom);
            rq.t_s  = 6'($urandom);
            rq.n_h  = 5'($urandom);
            rq.n_m  = 6'($urandom);
            rq.n_s  = 6'($urandom);
            return rq;
        end
        rq.slot = 3'($urandom_range(0, asl_pkg::NUM_SLOTS_DEF - 1));
        if (pick < 45) begin
            rq.req    = asl_pkg::REQ_TICK;
            day_clock = (day_clock + $urandom_range(1, 900)) % SECS_PER_DAY;
            due_t     = hms_of($urandom_range(0, SECS_PER_DAY - 1));
        end else if (pick < 70) begin
            rq.req = asl_pkg::REQ_ARM_REL;
            due_t  = hms_of($urandom_range(0, 2400));
        end else if (pick < 88) begin
            rq.req = asl_pkg::REQ_ARM_ABS;
            due_t  = hms_of((day_clock + SECS_PER_DAY + $urandom_range(0, 3000) - 600)
                            % SECS_PER_DAY);
        end else begin
            rq.req = asl_pkg::REQ_FREE;
            due_t  = hms_of($urandom_range(0, SECS_PER_DAY - 1));
        end
        now_t = hms_of(day_clock);
        rq.t_h = due_t.hour;
        rq.t_m = due_t.minute;
        rq.t_s = due_t.second;
        rq.n_h = now_t.hour;
        rq.n_m = now_t.minute;
        rq.n_s = now_t.second;
        return rq;
    endfunction

    // Drives one request until it is accepted, then records what it should report.
    task automatic issue_request(input t_alarm_req rq, input logic typed,
                                 input t_alarm_result want);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rq.req;
        s_axis_tdata  <= {3'b000, rq.n_s, rq.n_m, rq.n_h, rq.t_s, rq.t_m, rq.t_h, rq.slot};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        alarm_table_step(rq);
        if (typed) begin
            awaited_reports.push_back(want);
        end else begin
            foreach (step_reports[k]) awaited_reports.push_back(step_reports[k]);
        end
        if ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic wait_reports_drained();
        s_axis_tvalid <= 1'b0;
        while (awaited_reports.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : check_output
        t_alarm_result got;
        t_alarm_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tuser[0], m_axis_tdata[2:0], m_axis_tlast, m_axis_tdata[10:3]};
            if (awaited_reports.size() == 0) begin
                report_mismatch($sformatf("unexpected result, fired_slot %0d armed_mask %h",
                                          got.slot, got.mask));
            end else begin
                want = awaited_reports.pop_front();
                if (got.fire !== want.fire)
                    report_mismatch($sformatf("fire_valid got %0b want %0b",
                                              got.fire, want.fire));
                if (got.slot !== want.slot)
                    report_mismatch($sformatf("fired_slot got %0d want %0d",
                                              got.slot, want.slot));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last_result got %0b want %0b",
                                              got.last, want.last));
                if (got.mask !== want.mask)
                    report_mismatch($sformatf("armed_mask got %h want %h",
                                              got.mask, want.mask));
            end
        end
        if (rx_hold > 0) begin
            rx_hold       <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(99) < idle_pct) begin
            rx_hold       <= $urandom_range(0, 5);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        t_alarm_req    rq;
        asl_pkg::t_hms now_t;
        asl_pkg::t_hms due_t;
        int            sent;
        int            next_fill;
        logic          drained;
        t_alarm_result none;
        none = '0;
        foreach (due_hour[s]) begin
            due_hour[s] = '0;
            due_min[s]  = '0;
            due_sec[s]  = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) issue_request(dir_tab[k].rq, dir_tab[k].typed, dir_tab[k].want);
        wait_reports_drained();

        sent      = 0;
        next_fill = 40;
        drained   = 1'b0;
        day_clock = $urandom_range(0, SECS_PER_DAY - 1);
        while (sent < RAND_ITEMS) begin
            idle_pct = (sent < 60) ? 25 : (sent < 100) ? 0 : (sent < 150) ? 40 : 0;
            if (!drained && sent >= 100) begin
                wait_reports_drained();
                drained = 1'b1;
            end
            if (sent >= next_fill && sent < 150) begin
                // Arm every slot in the past, then one tick fires the whole table.
                now_t = hms_of(day_clock);
                for (int s = 0; s < asl_pkg::NUM_SLOTS_DEF; s++) begin
                    due_t = hms_of(day_clock -
                                   $urandom_range(0, day_clock < 3600 ? day_clock : 3600));
                    rq = '{asl_pkg::REQ_ARM_ABS, 3'(s), due_t.hour, due_t.minute,
                           due_t.second, now_t.hour, now_t.minute, now_t.second};
                    issue_request(rq, 1'b0, none);
                end
                rq.req = asl_pkg::REQ_TICK;
                issue_request(rq, 1'b0, none);
                sent      += asl_pkg::NUM_SLOTS_DEF + 1;
                next_fill += 50;
            end else begin
                issue_request(random_request(), 1'b0, none);
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (awaited_reports.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
